>>> src/ctm_pkg.sv
`timescale 1ns / 1ps

package ctm_pkg;

  // SAM op codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // control bits of one classified element, front to back
  typedef struct packed {
    logic err;   // unsupported op, not ignored
    logic nz;    // kept length is nonzero
    logic last;  // final element of the CIGAR
  } act_flags_t;

endpackage

>>> src/ctm_queue.sv
`timescale 1ns / 1ps

module ctm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic [IW:0]      count;

  assign full      = (count == (IW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/ctm_front.sv
`timescale 1ns / 1ps

module ctm_front #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 28,
  parameter int TRIM_BITS     = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              op,
  input  logic [LENGTH_BITS-1:0]  elem_length,
  input  logic                    elem_last,
  input  logic [TRIM_BITS-1:0]    trim_start,
  input  logic [TRIM_BITS-1:0]    trim_end,
  input  logic [TRIM_BITS:0]      trim_end_p1,
  input  logic                    by_reference,
  input  logic                    q_full,
  output logic                    push,
  output logic [3:0]              push_op,
  output logic [LENGTH_BITS-1:0]  push_kept,
  output ctm_pkg::act_flags_t     push_flags
);

  import ctm_pkg::*;

  localparam int PW = POSITION_BITS + 2;
  localparam int EW = ((PW > LENGTH_BITS) ? PW : LENGTH_BITS) + 1;

  logic [PW-1:0] position;
  logic [PW-1:0] position_next;
  logic          stopped;
  logic          stopped_next;

  // stage A: classified element
  logic                   a_valid;
  logic [3:0]             a_op;
  logic [LENGTH_BITS-1:0] a_len;
  logic [PW-1:0]          a_pos;
  logic [EW-1:0]          a_end;
  logic                   a_copy;
  logic                   a_clip;
  logic                   a_err;
  logic                   a_last;

  logic          take;
  logic          is_d, is_mx, is_si;
  logic          stop_now, halted;
  logic          cls_copy, cls_clip;
  logic [EW-1:0] pos_sum;

  logic [EW-1:0]          lo, hi;
  logic [EW-1:0]          span;
  logic [LENGTH_BITS-1:0] kept;

  assign in_stall = a_valid && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    is_d     = (op == OP_D);
    is_mx    = (op == OP_M) || (op == OP_EQ) || (op == OP_X);
    is_si    = (op == OP_S) || (op == OP_I);
    stop_now = !stopped && (position > PW'(trim_end)) && (by_reference || !is_d);
    halted   = stopped || stop_now;
    cls_copy = (is_d && !by_reference) || (is_si && by_reference);
    cls_clip = (is_d && by_reference) || is_mx || (is_si && !by_reference);
    pos_sum  = EW'(position) + EW'(elem_length);

    position_next = position;
    stopped_next  = stopped;
    if (take) begin
      if (elem_last) begin
        position_next = '0;
        stopped_next  = 1'b0;
      end else begin
        stopped_next = halted;
        if (!halted && cls_clip) begin
          position_next = pos_sum[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      stopped  <= 1'b0;
      a_valid  <= 1'b0;
    end else begin
      position <= position_next;
      stopped  <= stopped_next;
      if (take) begin
        a_valid <= 1'b1;
      end else if (push) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op   <= op;
      a_len  <= elem_length;
      a_pos  <= position;
      a_end  <= pos_sum;
      a_copy <= !halted && cls_copy;
      a_clip <= !halted && cls_clip;
      a_err  <= !halted && !cls_copy && !cls_clip;
      a_last <= elem_last;
    end
  end

  // stage B: window overlap [max(pos,start), min(end,trim_end+1))
  always_comb begin
    lo   = (EW'(a_pos) > EW'(trim_start)) ? EW'(a_pos) : EW'(trim_start);
    hi   = (a_end < EW'(trim_end_p1)) ? a_end : EW'(trim_end_p1);
    span = hi - lo;
    kept = '0;
    if (a_clip) begin
      if (hi > lo) begin
        kept = span[LENGTH_BITS-1:0];
      end
    end else if (a_copy) begin
      if (a_pos >= PW'(trim_start)) begin
        kept = a_len;
      end
    end
  end

  assign push            = a_valid && !q_full;
  assign push_op         = a_op;
  assign push_kept       = kept;
  assign push_flags.err  = a_err;
  assign push_flags.nz   = (kept != '0);
  assign push_flags.last = a_last;

endmodule

>>> src/ctm_back.sv
`timescale 1ns / 1ps

module ctm_back #(
  parameter int LENGTH_BITS = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [3:0]             q_op,
  input  logic [LENGTH_BITS-1:0] q_kept,
  input  ctm_pkg::act_flags_t    q_flags,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             out_op,
  output logic [31:0]            out_length,
  output logic                   out_last,
  output logic                   status
);

  import ctm_pkg::*;

  logic        pend_valid;
  logic [3:0]  pend_op;
  logic [31:0] pend_len;
  logic        error_seen;
  logic        split;  // flush already sent, final still owed

  logic        nz, err_now, same, flush, need_out, out_free, fire;
  logic [32:0] sum;
  logic [31:0] kept32, merged;
  logic        nxt_valid;
  logic [3:0]  nxt_op;
  logic [31:0] nxt_len;

  always_comb begin
    nz       = q_flags.nz && !split;
    err_now  = error_seen || q_flags.err;
    same     = pend_valid && (pend_op == q_op);
    flush    = nz && pend_valid && !same;
    need_out = flush || q_flags.last;
    out_free = !out_valid || !out_stall;
    fire     = q_valid && (!need_out || out_free);
    pop      = fire && !(flush && q_flags.last);

    kept32 = 32'(q_kept);
    sum    = {1'b0, pend_len} + {1'b0, kept32};
    merged = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    nxt_valid = pend_valid || nz;
    nxt_op    = (nz && !same) ? q_op : pend_op;
    nxt_len   = nz ? (same ? merged : kept32) : pend_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      error_seen <= 1'b0;
      split      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (q_flags.last && !flush) begin
          pend_valid <= 1'b0;
          error_seen <= 1'b0;
          split      <= 1'b0;
          out_valid  <= 1'b1;
        end else begin
          pend_valid <= nxt_valid;
          error_seen <= err_now;
          split      <= q_flags.last;
          if (flush) begin
            out_valid <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_op  <= nxt_op;
      pend_len <= nxt_len;
      if (flush) begin
        out_op     <= pend_op;
        out_length <= pend_len;
        out_last   <= 1'b0;
        status     <= err_now;
      end else if (q_flags.last) begin
        out_op     <= nxt_valid ? nxt_op : OP_M;
        out_length <= nxt_valid ? nxt_len : 32'd0;
        out_last   <= 1'b1;
        status     <= err_now;
      end
    end
  end

endmodule

>>> src/cigar_trim_and_merge_core.sv
`timescale 1ns / 1ps
// CIGAR trim and run merge.
// Input channel (in_valid/in_stall): one CIGAR element per transaction, op,
// elem_length and elem_last; elem_last closes the CIGAR. Output channel
// (out_valid/out_stall): merged elements of the CIGAR cut to the inclusive
// window trim_start..trim_end, out_last on the final one, status = 1 when
// an N, H, P or unknown op was seen in that CIGAR before the trim stopped.
// An empty trim gives one transaction with op M, length 0 and out_last set.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 trim_start,
// 1 trim_end, 2 by_reference; write only while the block is drained.
// Throughput: one element per cycle while in_stall is low. An element that both
// closes a run and ends the CIGAR makes two results and holds the back end
// until the second one is sent. A result passes the classify stage, the queue
// and the output register after the element that releases it is taken.
// A 4-entry queue between the classify front end and the merge back end
// absorbs output stalls; in_stall rises only once that queue is full.
// Reset: synchronous, clears the window to 0..0, reference mode, and all
// per-CIGAR state; a held output is dropped.
module cigar_trim_and_merge_core #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 28
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             op,
  input  logic [LENGTH_BITS-1:0] elem_length,
  input  logic                   elem_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             out_op,
  output logic [31:0]            out_length,
  output logic                   out_last,
  output logic                   status
);

  import ctm_pkg::*;

  // window registers hold at most 32 bits
  localparam int TRIM_BITS   = (POSITION_BITS < 32) ? POSITION_BITS : 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int FLAG_BITS   = $bits(act_flags_t);
  localparam int REC_BITS    = 4 + LENGTH_BITS + FLAG_BITS;

  localparam logic [1:0] REG_TRIM_START   = 2'd0;
  localparam logic [1:0] REG_TRIM_END     = 2'd1;
  localparam logic [1:0] REG_BY_REFERENCE = 2'd2;

  logic [TRIM_BITS-1:0] trim_start;
  logic [TRIM_BITS-1:0] trim_end;
  logic [TRIM_BITS:0]   trim_end_p1;  // exclusive upper bound
  logic                 by_reference;

  logic                   push, pop, q_full, q_valid;
  logic [3:0]             push_op, q_op;
  logic [LENGTH_BITS-1:0] push_kept, q_kept;
  act_flags_t             push_flags, q_flags;
  logic [REC_BITS-1:0]    push_rec, pop_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_start   <= '0;
      trim_end     <= '0;
      trim_end_p1  <= (TRIM_BITS+1)'(1);
      by_reference <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRIM_START: begin
          trim_start <= cfg_data[TRIM_BITS-1:0];
        end
        REG_TRIM_END: begin
          trim_end    <= cfg_data[TRIM_BITS-1:0];
          trim_end_p1 <= (TRIM_BITS+1)'(cfg_data[TRIM_BITS-1:0]) + 1'b1;
        end
        REG_BY_REFERENCE: begin
          by_reference <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: position tracking, stop detection, clip to the window
  ctm_front #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .TRIM_BITS     (TRIM_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .elem_length  (elem_length),
    .elem_last    (elem_last),
    .trim_start   (trim_start),
    .trim_end     (trim_end),
    .trim_end_p1  (trim_end_p1),
    .by_reference (by_reference),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op),
    .push_kept    (push_kept),
    .push_flags   (push_flags)
  );

  assign push_rec = {push_op, push_kept, push_flags};
  assign {q_op, q_kept, q_flags} = pop_rec;

  ctm_queue #(
    .WIDTH (REC_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (pop),
    .pop_data  (pop_rec),
    .full      (q_full),
    .not_empty (q_valid)
  );

  // back: run merge, saturation, final flush
  ctm_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_kept     (q_kept),
    .q_flags    (q_flags),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_op     (out_op),
    .out_length (out_length),
    .out_last   (out_last),
    .status     (status)
  );

endmodule

>>> src/ctm_checker.sv
`timescale 1ns / 1ps

module ctm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_op,
  input logic [31:0] out_length,
  input logic        out_last,
  input logic        status
);

  import ctm_pkg::*;

  // reset empties both sides
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("ctm: not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_op) && $stable(out_length)
      && $stable(out_last) && $stable(status))
    else $error("ctm: stalled output changed");

  // zero length only as the empty-CIGAR marker
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_length == 32'd0) |-> out_last && (out_op == OP_M))
    else $error("ctm: zero-length element inside a CIGAR");

  a_out_op: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_op == OP_M) || (out_op == OP_I) || (out_op == OP_D)
      || (out_op == OP_S) || (out_op == OP_EQ) || (out_op == OP_X))
    else $error("ctm: unsupported op emitted");

  // error status is sticky until the end of the CIGAR
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_last && status |=> !out_valid || status)
    else $error("ctm: status dropped inside a CIGAR");

endmodule

bind cigar_trim_and_merge_core ctm_checker u_ctm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_op     (out_op),
  .out_length (out_length),
  .out_last   (out_last),
  .status     (status)
);

>>> tb/sv/ctm_trim_checker.sv
`timescale 1ns / 1ps

package ctm_tb_regs;

  // config register indexes
  localparam logic [1:0] REG_TRIM_START   = 2'd0;
  localparam logic [1:0] REG_TRIM_END     = 2'd1;
  localparam logic [1:0] REG_BY_REFERENCE = 2'd2;
  localparam logic [1:0] REG_UNUSED       = 2'd3;

  // SAM ops the design package leaves out
  localparam logic [3:0] OP_N = 4'd3;
  localparam logic [3:0] OP_H = 4'd5;
  localparam logic [3:0] OP_P = 4'd6;

endpackage

module ctm_trim_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  op,
  input  logic [27:0] elem_length,
  input  logic        elem_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_op,
  input  logic [31:0] out_length,
  input  logic        out_last,
  input  logic        status,
  output int          fail_count,
  output int          owed_results
);
  import ctm_pkg::*;
  import ctm_tb_regs::*;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] length;
    logic        last;
    logic        status;
  } trim_elem_t;

  // window registers
  logic [31:0] win_start;
  logic [31:0] win_end;
  logic        count_ref;

  // per-CIGAR state
  logic [33:0] pos;
  logic        stopped;
  logic        run_valid;
  logic [3:0]  run_op;
  logic [31:0] run_len;
  logic        bad_op_seen;

  trim_elem_t  trimmed_q[$];
  int          fails = 0;

  task automatic clear_cigar;
    pos         = '0;
    stopped     = 1'b0;
    run_valid   = 1'b0;
    run_op      = OP_M;
    run_len     = '0;
    bad_op_seen = 1'b0;
  endtask

  // clip/copy one element, merge into the open run, queue what it releases
  task automatic trim_and_merge(input logic [3:0] o, input logic [27:0] len,
                                input logic lst);
    longint      hi;
    longint      lo;
    longint      ws;
    longint      we;
    longint      kept_s;
    logic [31:0] kept;
    logic [32:0] total;
    logic        copy;
    logic        clip;
    kept = '0;
    copy = 1'b0;
    clip = 1'b0;
    if (!stopped && pos > {2'b00, win_end} && (count_ref || o != OP_D))
      stopped = 1'b1;
    if (!stopped) begin
      case (o)
        OP_D: begin
          if (count_ref) clip = 1'b1;
          else copy = 1'b1;
        end
        OP_M, OP_EQ, OP_X: clip = 1'b1;
        OP_S, OP_I: begin
          if (count_ref) copy = 1'b1;
          else clip = 1'b1;
        end
        default: bad_op_seen = 1'b1;
      endcase
      if (copy && pos >= {2'b00, win_start}) begin
        kept = {4'b0, len};
      end else if (clip) begin
        lo = pos;
        ws = win_start;
        we = win_end;
        hi = lo + len - 1;
        if (hi > we) hi = we;
        if (lo < ws) lo = ws;
        kept_s = hi - lo + 1;
        if (kept_s > 0) kept = kept_s[31:0];
        pos = pos + len;
      end
      if (kept != 0) begin
        if (run_valid && run_op == o) begin
          total   = {1'b0, run_len} + {1'b0, kept};
          run_len = total[32] ? 32'hFFFF_FFFF : total[31:0];
        end else begin
          if (run_valid)
            trimmed_q.push_back(trim_elem_t'{run_op, run_len, 1'b0, bad_op_seen});
          run_valid = 1'b1;
          run_op    = o;
          run_len   = kept;
        end
      end
    end
    if (lst) begin
      if (run_valid)
        trimmed_q.push_back(trim_elem_t'{run_op, run_len, 1'b1, bad_op_seen});
      else
        trimmed_q.push_back(trim_elem_t'{OP_M, 32'd0, 1'b1, bad_op_seen});
      clear_cigar();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    trim_elem_t want;
    if (rst) begin
      win_start = '0;
      win_end   = '0;
      count_ref = 1'b1;
      clear_cigar();
      trimmed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (trimmed_q.size() == 0) begin
          $error("unexpected transaction: op %0d length %0d last %0d",
                 out_op, out_length, out_last);
          fails++;
        end else begin
          want = trimmed_q.pop_front();
          check_field("out_op", want.op, out_op);
          check_field("out_length", want.length, out_length);
          check_field("out_last", want.last, out_last);
          check_field("status", want.status, status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRIM_START:   win_start = cfg_data;
          REG_TRIM_END:     win_end = cfg_data;
          REG_BY_REFERENCE: count_ref = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        trim_and_merge(op, elem_length, elem_last);
    end
    owed_results <= trimmed_q.size();
    fail_count   <= fails;
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the CIGAR trimmer. The checker beside the block
// predicts every output transaction; this module only drives the channels.
module testbench;
  import ctm_pkg::*;
  import ctm_tb_regs::*;

  // settle time after the output goes quiet: classify stage, 4-deep queue,
  // output register, plus margin for elements that release nothing
  localparam int DRAIN_SETTLE = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_WINDOW = 35;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_TRIM_START;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  op = OP_M;
  logic [27:0] elem_length = '0;
  logic        elem_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_op;
  logic [31:0] out_length;
  logic        out_last;
  logic        status;

  int          fail_count;
  int          owed_results;
  int          idle_pct = 0;   // sender idle chance per cycle
  int          stall_pct = 0;  // receiver stall chance per cycle
  int unsigned cycles = 0;

  always #1 clk = ~clk;

  cigar_trim_and_merge_core u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .elem_length (elem_length),
    .elem_last   (elem_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_op      (out_op),
    .out_length  (out_length),
    .out_last    (out_last),
    .status      (status)
  );

  ctm_trim_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .elem_length  (elem_length),
    .elem_last    (elem_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_op       (out_op),
    .out_length   (out_length),
    .out_last     (out_last),
    .status       (status),
    .fail_count   (fail_count),
    .owed_results (owed_results)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("cigar_trim_and_merge_core: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle. One nonblocking write per
  // step, so a stall that stays high is never dropped and re-raised.
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // One config transaction. cfg_valid is left high so back-to-back writes
  // never lower and raise it in the same step; the caller drops it.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_window(input logic [31:0] first, input logic [31:0] final_pos,
                            input logic by_ref);
    cfg_write(REG_TRIM_START, first);
    cfg_write(REG_TRIM_END, final_pos);
    cfg_write(REG_BY_REFERENCE, {31'b0, by_ref});
    cfg_valid <= 1'b0;
  endtask

  // One CIGAR element transaction. An idle gap lowers valid between
  // elements; otherwise valid stays high into the next element.
  task automatic put_elem(input logic [3:0] o, input logic [27:0] len,
                          input logic lst);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    elem_length <= len;
    elem_last   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender off until every predicted result is out, then give
  // the pipeline time to swallow elements that release nothing.
  task automatic wait_for_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results != 0) @(posedge clk);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  // Mostly consuming ops; a small share of N/H/P and undefined codes as noise.
  function automatic logic [3:0] pick_op;
    int r;
    r = $urandom_range(99);
    if (r < 30) return OP_M;
    if (r < 42) return OP_I;
    if (r < 54) return OP_D;
    if (r < 64) return OP_S;
    if (r < 74) return OP_EQ;
    if (r < 84) return OP_X;
    if (r < 87) begin
      r = $urandom_range(2);
      return (r == 0) ? OP_N : (r == 1) ? OP_H : OP_P;
    end
    if (r < 90) return 4'($urandom_range(9, 15));
    return OP_M;
  endfunction

  // Short lengths keep the window edges busy; a few full-width ones toggle
  // every length bit and push the position past 32 bits in long CIGARs.
  function automatic logic [27:0] pick_length(input bit big);
    logic [27:0] v;
    int r;
    v = 28'($urandom);
    if (big) return v | 28'hC00_0000;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 88) return 28'($urandom_range(1, 30));
    if (r < 96) return 28'($urandom_range(31, 4095));
    return v;
  endfunction

  task automatic send_random_cigar(inout int count);
    int n;
    int i;
    bit big;
    big = ($urandom_range(24) == 0);
    n = big ? $urandom_range(12, 20) : $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      put_elem(pick_op(), pick_length(big), i == n - 1);
      count++;
    end
  endtask

  initial begin : stimulus
    int ph;
    int k;
    int i;
    int items_here;
    logic [31:0] ws;
    logic [31:0] we;
    logic mode;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // reset window 0..0 in reference mode: one base kept
    put_elem(OP_M, 28'd3, 1'b1);
    wait_for_drain();

    // unused index must not disturb anything; then window 5..20 by reference
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    set_window(32'd5, 32'd20, 1'b1);

    // leading M outside the window, S before start (dropped), clip into
    // window, inserts copied, zero-length dropped, D clipped, EQ cut at the
    // end, X past the end stops the trim, later N ignored without error
    put_elem(OP_M, 28'd3, 1'b0);
    put_elem(OP_S, 28'd4, 1'b0);
    put_elem(OP_M, 28'd10, 1'b0);
    put_elem(OP_I, 28'd2, 1'b0);
    put_elem(OP_I, 28'd0, 1'b0);
    put_elem(OP_D, 28'd3, 1'b0);
    put_elem(OP_M, 28'd0, 1'b0);
    put_elem(OP_M, 28'd4, 1'b0);
    put_elem(OP_EQ, 28'd2, 1'b0);
    put_elem(OP_X, 28'd5, 1'b0);
    put_elem(OP_M, 28'd5, 1'b0);
    put_elem(OP_N, 28'd3, 1'b0);
    put_elem(OP_M, 28'd1, 1'b1);

    // unsupported ops raise status; max length on an undefined code
    put_elem(OP_H, 28'd5, 1'b0);
    put_elem(OP_N, 28'd2, 1'b0);
    put_elem(OP_M, 28'd6, 1'b0);
    put_elem(4'hF, 28'hFFF_FFFF, 1'b0);
    put_elem(OP_P, 28'd0, 1'b1);

    // nothing lands in the window: empty CIGAR marker
    put_elem(OP_M, 28'd2, 1'b1);

    // sender pauses mid-CIGAR until the output is empty; the open run must
    // survive the pause and merge with the next M
    put_elem(OP_M, 28'd10, 1'b0);
    wait_for_drain();
    put_elem(OP_M, 28'd10, 1'b1);
    wait_for_drain();

    // --- random ---
    // Four pacing phases: none, sender idle, receiver stall, both. Each runs
    // through five windows: full range, small, reversed, extreme or wide, read mode.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      for (k = 0; k < 5; k++) begin
        case (k)
          0: begin
            ws = '0;
            we = 32'hFFFF_FFFF;
            mode = (ph == 0) ? 1'b1 : 1'($urandom_range(1));
          end
          1: begin
            ws = $urandom_range(0, 40);
            we = ws + $urandom_range(0, 60);
            mode = 1'b1;
          end
          2: begin
            we = $urandom_range(0, 30);
            ws = we + $urandom_range(1, 30);
            mode = 1'($urandom_range(1));
          end
          3: begin
            if (ph % 2 == 0) begin
              ws = 32'hFFFF_FFFF;
              we = 32'hFFFF_FFFF;
            end else begin
              ws = $urandom_range(0, 20);
              we = $urandom;
            end
            mode = 1'($urandom_range(1));
          end
          default: begin
            ws = $urandom_range(0, 40);
            we = ws + $urandom_range(0, 60);
            mode = 1'b0;
          end
        endcase
        wait_for_drain();
        set_window(ws, we, mode);
        items_here = 0;

        // full window in reference mode: a run of max-length inserts
        // overflows the merged length and must saturate
        if (ph == 0 && k == 0) begin
          for (i = 0; i < 17; i++) begin
            put_elem(OP_I, 28'hFFF_FFFF, i == 16);
            items_here++;
          end
        end

        while (items_here < ITEMS_PER_WINDOW) send_random_cigar(items_here);
      end
    end

    // let the tail drain, then one last quiet stretch
    wait_for_drain();
    repeat (DRAIN_SETTLE) @(posedge clk);
    if (fail_count == 0 && owed_results == 0)
      $display("cigar_trim_and_merge_core: match");
    else
      $display("cigar_trim_and_merge_core: mismatch");
    $finish;
  end

endmodule
